// ===== hdl/pid_antiwindup_filtered_derivative_defines.svh =====
// Assertion macros used by the checker file of the PID block.
`ifndef PID_ANTIWINDUP_FILTERED_DERIVATIVE_DEFINES_SVH
`define PID_ANTIWINDUP_FILTERED_DERIVATIVE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDAW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pid block check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIDAW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pid block check failed");

`endif

// ===== hdl/pidaw_pkg.sv =====
// Package with payload types, register indexes and saturation helper for the PID block.
package pidaw_pkg;

	localparam int DataWidth = 32;
	localparam int GainWidth = 32;
	localparam int AlphaWidth = 17;
	localparam int AccWidth = 48;
	localparam int AddrWidth = 5;

	// Register indexes on the configuration port.
	localparam logic [2:0] RegPropGain = 3'd0;
	localparam logic [2:0] RegIntegGain = 3'd1;
	localparam logic [2:0] RegDerivGain = 3'd2;
	localparam logic [2:0] RegWindupGain = 3'd3;
	localparam logic [2:0] RegFilterAlpha = 3'd4;

	localparam logic [AlphaWidth-1:0] AlphaOne = 17'd65536;

	typedef struct packed {
		logic mode;
		logic signed [DataWidth-1:0] setpoint;
		logic signed [DataWidth-1:0] measured;
	} in_t;

	typedef struct packed {
		logic [9:0] drive;
		logic direction;
	} out_t;

	// Saturate a wide signed value to the 48-bit signed accumulator range.
	function automatic logic signed [AccWidth-1:0] sat48(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_7FFF_FFFF_FFFF;
		lo = -64'sh0000_8000_0000_0000;
		if (x > hi) begin
			return hi[AccWidth-1:0];
		end else if (x < lo) begin
			return lo[AccWidth-1:0];
		end
		return x[AccWidth-1:0];
	endfunction

endpackage

// ===== hdl/pid_antiwindup_filtered_derivative.sv =====
// Handles one item at a time: a new input is taken only after the previous result is in the output
// register. Each product is formed in the bit-serial shift-add multiplier, and the divide by 200
// is a bit-serial restoring divider.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low) clears all controller state, gains to zero and alpha to one.
module pid_antiwindup_filtered_derivative (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pidaw_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output pidaw_pkg::out_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pidaw_pkg::AddrWidth-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int DW = pidaw_pkg::DataWidth;
	localparam int AW = pidaw_pkg::AccWidth;
	localparam int OPW = (DW + 2 > AW) ? DW + 2 : AW;
	localparam int CW = $clog2(OPW + 1);
	localparam int QW = 2 * OPW - 15;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_LOAD = 4'd1;
	localparam logic [3:0] ST_START = 4'd2;
	localparam logic [3:0] ST_MUL = 4'd3;
	localparam logic [3:0] ST_MRES = 4'd4;
	localparam logic [3:0] ST_ACC = 4'd5;
	localparam logic [3:0] ST_DIVS = 4'd6;
	localparam logic [3:0] ST_DIV = 4'd7;
	localparam logic [3:0] ST_DRES = 4'd8;
	localparam logic [3:0] ST_SUM = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	// Product steps.
	localparam logic [2:0] STEP_P = 3'd0;
	localparam logic [2:0] STEP_I = 3'd1;
	localparam logic [2:0] STEP_B = 3'd2;
	localparam logic [2:0] STEP_D = 3'd3;
	localparam logic [2:0] STEP_FA = 3'd4;
	localparam logic [2:0] STEP_FB = 3'd5;

	localparam logic [7:0] RATE_DIV = 8'd200;
	localparam logic signed [AW-1:0] LIM_HI = 48'sd65536000;
	localparam logic signed [AW-1:0] LIM_LO_POS = -48'sd65536000;

	logic [3:0] state_q;
	logic [2:0] step_q;
	logic [CW-1:0] cnt_q;

	logic signed [pidaw_pkg::GainWidth-1:0] kp_q, ki_q, kd_q, kb_q;
	logic [pidaw_pkg::AlphaWidth-1:0] alpha_q;

	logic signed [AW-1:0] integ_q [2];
	logic signed [DW:0] prev_q [2];
	logic signed [AW-1:0] filt_q [2];
	logic signed [AW-1:0] cex_q;
	logic hdir_q;

	logic mode_q;
	logic signed [DW:0] err_q;
	logic signed [DW+1:0] diff_q;
	logic signed [AW-1:0] up_q, w_q, ui_q, ud_q, udf_q, term_q, mres_q;

	logic [OPW-1:0] mul_a_q;
	logic [2*OPW-1:0] mul_p_q;
	logic mul_neg_q;

	logic [AW-1:0] div_d_q;
	logic [7:0] div_r_q;
	logic div_neg_q;

	logic out_valid_q;
	pidaw_pkg::out_t out_q;

	logic cfg_wr;
	logic [pidaw_pkg::AlphaWidth-1:0] alpha_eff;
	logic signed [OPW-1:0] opa, opb;
	logic [OPW:0] mul_sum;
	logic [QW-1:0] q_val, q_lim, q_mag;
	logic signed [AW-1:0] mul_res;
	logic [8:0] div_r2;
	logic div_ge;
	logic signed [AW-1:0] div_q;
	logic signed [63:0] scaled;
	logic signed [AW-1:0] lim_lo, sat_val;
	logic [AW-1:0] sat_mag;
	logic out_free;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_free = !out_valid_q || out_ready;

	// Register read-back.
	always_comb begin
		case (paddr[4:2])
			pidaw_pkg::RegPropGain: prdata = kp_q;
			pidaw_pkg::RegIntegGain: prdata = ki_q;
			pidaw_pkg::RegDerivGain: prdata = kd_q;
			pidaw_pkg::RegWindupGain: prdata = kb_q;
			pidaw_pkg::RegFilterAlpha: prdata = 32'(alpha_q);
			default: prdata = '0;
		endcase
	end

	// Alpha above one acts as one.
	assign alpha_eff = (alpha_q > pidaw_pkg::AlphaOne) ? pidaw_pkg::AlphaOne : alpha_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		case (step_q)
			STEP_P: begin
				opa = OPW'(kp_q);
				opb = OPW'(err_q);
			end
			STEP_I: begin
				opa = OPW'(ki_q);
				opb = OPW'(err_q);
			end
			STEP_B: begin
				opa = OPW'(kb_q);
				opb = OPW'(cex_q);
			end
			STEP_D: begin
				opa = OPW'(kd_q);
				opb = OPW'(diff_q);
			end
			STEP_FA: begin
				opa = OPW'(signed'({1'b0, alpha_eff}));
				opb = OPW'(ud_q);
			end
			STEP_FB: begin
				opa = OPW'(signed'({1'b0, pidaw_pkg::AlphaOne - alpha_eff}));
				opb = OPW'(filt_q[mode_q]);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// One shift-add step of the multiplier.
	assign mul_sum = {1'b0, mul_p_q[2*OPW-1:OPW]} + (mul_p_q[0] ? {1'b0, mul_a_q} : '0);

	// Product scaling: shift right 16 with floor, then saturate to 48 bits.
	always_comb begin
		q_val = {1'b0, mul_p_q[2*OPW-1:16]}
			+ QW'(mul_neg_q && (mul_p_q[15:0] != 16'd0));
		q_lim = mul_neg_q ? (QW'(1) << (AW - 1)) : ((QW'(1) << (AW - 1)) - QW'(1));
		q_mag = (q_val > q_lim) ? q_lim : q_val;
		mul_res = mul_neg_q ? -signed'(q_mag[AW-1:0]) : signed'(q_mag[AW-1:0]);
	end

	// One restoring step of the divide by 200.
	assign div_r2 = {div_r_q, div_d_q[AW-1]};
	assign div_ge = (div_r2 >= {1'b0, RATE_DIV});
	assign div_q = div_neg_q
		? -signed'(div_d_q + AW'(div_r_q != 8'd0))
		: signed'(div_d_q);

	// Derivative term scaled by 200 as shifts and adds.
	assign scaled = (64'(mres_q) <<< 7) + (64'(mres_q) <<< 6) + (64'(mres_q) <<< 3);

	// Output clamp.
	always_comb begin
		lim_lo = mode_q ? LIM_LO_POS : '0;
		if (term_q > LIM_HI) begin
			sat_val = LIM_HI;
		end else if (term_q < lim_lo) begin
			sat_val = lim_lo;
		end else begin
			sat_val = term_q;
		end
		sat_mag = sat_val[AW-1] ? AW'(-sat_val) : AW'(sat_val);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			kb_q <= '0;
			alpha_q <= pidaw_pkg::AlphaOne;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				pidaw_pkg::RegPropGain: kp_q <= pwdata;
				pidaw_pkg::RegIntegGain: ki_q <= pwdata;
				pidaw_pkg::RegDerivGain: kd_q <= pwdata;
				pidaw_pkg::RegWindupGain: kb_q <= pwdata;
				pidaw_pkg::RegFilterAlpha: alpha_q <= pwdata[pidaw_pkg::AlphaWidth-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, datapath and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_P;
			cnt_q <= '0;
			integ_q[0] <= '0;
			integ_q[1] <= '0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
			filt_q[0] <= '0;
			filt_q[1] <= '0;
			cex_q <= '0;
			hdir_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The done state reloads the output register itself when it is free.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q <= in_data.mode;
						err_q <= (DW + 1)'(in_data.setpoint) - (DW + 1)'(in_data.measured);
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					diff_q <= (DW + 2)'(err_q) - (DW + 2)'(prev_q[mode_q]);
					step_q <= STEP_P;
					state_q <= ST_START;
				end
				ST_START: begin
					mul_a_q <= opa[OPW-1] ? OPW'(-opa) : OPW'(opa);
					mul_p_q <= {OPW'(0), (opb[OPW-1] ? OPW'(-opb) : OPW'(opb))};
					mul_neg_q <= opa[OPW-1] ^ opb[OPW-1];
					cnt_q <= CW'(OPW);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					mul_p_q <= {mul_sum, mul_p_q[OPW-1:1]};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_MRES;
					end
				end
				ST_MRES: begin
					mres_q <= mul_res;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					case (step_q)
						STEP_P: begin
							up_q <= mres_q;
							step_q <= STEP_I;
							state_q <= ST_START;
						end
						STEP_I: begin
							w_q <= mres_q;
							if (!mode_q) begin
								step_q <= STEP_B;
								state_q <= ST_START;
							end else begin
								state_q <= ST_DIVS;
							end
						end
						STEP_B: begin
							w_q <= pidaw_pkg::sat48(64'(w_q) + 64'(mres_q));
							state_q <= ST_DIVS;
						end
						STEP_D: begin
							ud_q <= pidaw_pkg::sat48(scaled);
							step_q <= STEP_FA;
							state_q <= ST_START;
						end
						STEP_FA: begin
							udf_q <= mres_q;
							step_q <= STEP_FB;
							state_q <= ST_START;
						end
						STEP_FB: begin
							udf_q <= pidaw_pkg::sat48(64'(udf_q) + 64'(mres_q));
							state_q <= ST_SUM;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_DIVS: begin
					div_d_q <= w_q[AW-1] ? AW'(-w_q) : AW'(w_q);
					div_neg_q <= w_q[AW-1];
					div_r_q <= '0;
					cnt_q <= CW'(AW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					div_r_q <= div_ge ? 8'(div_r2 - {1'b0, RATE_DIV}) : div_r2[7:0];
					div_d_q <= {div_d_q[AW-2:0], div_ge};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_DRES;
					end
				end
				ST_DRES: begin
					ui_q <= pidaw_pkg::sat48(64'(integ_q[mode_q]) + 64'(div_q));
					step_q <= STEP_D;
					state_q <= ST_START;
				end
				ST_SUM: begin
					term_q <= pidaw_pkg::sat48(64'(up_q) + 64'(ui_q) + 64'(udf_q));
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						integ_q[mode_q] <= ui_q;
						prev_q[mode_q] <= err_q;
						filt_q[mode_q] <= udf_q;
						out_q.drive <= sat_mag[25:16];
						if (!mode_q) begin
							cex_q <= pidaw_pkg::sat48(64'(sat_val) - 64'(term_q));
							out_q.direction <= 1'b1;
						end else if (sat_val > 0) begin
							hdir_q <= 1'b1;
							out_q.direction <= 1'b1;
						end else if (sat_val < 0) begin
							hdir_q <= 1'b0;
							out_q.direction <= 1'b0;
						end else begin
							out_q.direction <= hdir_q;
						end
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/pidaw_checker.sv =====
// Port-level checker for the PID block and its bind statement.
`include "pid_antiwindup_filtered_derivative_defines.svh"

module pidaw_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input pidaw_pkg::in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input pidaw_pkg::out_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pidaw_pkg::AddrWidth-1:0] paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic pready
);

	// The configuration port never inserts wait states.
	`PIDAW_ASSERT_IMPLY(a_pready_high, clk, arst_n, 1'b1, pready)

	// A delivered drive never exceeds the clamp limit.
	`PIDAW_ASSERT_IMPLY(a_drive_range, clk, arst_n, out_valid, out_data.drive <= 10'd1000)

	// After a transaction on the input the block is busy with that item.
	`PIDAW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// A stalled result stays put.
	`PIDAW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind pid_antiwindup_filtered_derivative pidaw_checker u_pidaw_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the PID controller with anti-windup and a filtered derivative.
`timescale 1ns / 1ps

module tb_top;

	localparam logic ModeVelocity = 1'b0;
	localparam logic ModePosition = 1'b1;
	localparam longint OutHigh = 1000 * 65536;
	localparam longint OutLowPos = -1000 * 65536;
	localparam longint Acc48Max = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint Acc48Min = -64'sh0000_8000_0000_0000;
	localparam longint UnitQ16 = 65536;
	localparam logic [2:0] RegUnused = 3'd6;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pidaw_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	pidaw_pkg::out_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [pidaw_pkg::AddrWidth-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Controller state shadowed by the testbench.
	longint kp_q, ki_q, kd_q, kb_q;
	longint alpha_q;
	longint integ_acc[2];
	longint last_err[2];
	longint deriv_filt[2];
	longint vel_excess;
	logic dir_hold;

	pidaw_pkg::out_t drive_expected[$];
	bit failed;
	bit calm;
	int hold_off_cycles;

	pid_antiwindup_filtered_derivative i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic longint clip48(longint x);
		if (x > Acc48Max) begin
			return Acc48Max;
		end else if (x < Acc48Min) begin
			return Acc48Min;
		end
		return x;
	endfunction

	// Exact Q16 product, floored, then limited to 48 bits.
	function automatic longint qmul(longint a, longint b);
		logic signed [127:0] pa;
		logic signed [127:0] pb;
		logic signed [127:0] p;
		pa = a;
		pb = b;
		p = (pa * pb) >>> 16;
		if (p > 128'sh7FFF_FFFF_FFFF) begin
			return Acc48Max;
		end else if (p < -128'sh8000_0000_0000) begin
			return Acc48Min;
		end
		return longint'(p);
	endfunction

	function automatic longint floor_div200(longint x);
		if (x >= 0) begin
			return x / 200;
		end
		return -((-x + 199) / 200);
	endfunction

	// One control step; updates the shadow state and returns the drive word.
	function automatic pidaw_pkg::out_t pid_step(pidaw_pkg::in_t s);
		pidaw_pkg::out_t r;
		int m;
		longint err, up, w, ui, ud, udf, term, sat, lo, mag, alpha;
		m = s.mode;
		err = longint'(s.setpoint) - longint'(s.measured);
		alpha = (alpha_q > UnitQ16) ? UnitQ16 : alpha_q;
		up = qmul(kp_q, err);
		w = qmul(ki_q, err);
		if (s.mode == ModeVelocity) begin
			w = clip48(w + qmul(kb_q, vel_excess));
		end
		ui = clip48(integ_acc[m] + floor_div200(w));
		ud = clip48(200 * qmul(kd_q, err - last_err[m]));
		udf = clip48(qmul(alpha, ud) + qmul(UnitQ16 - alpha, deriv_filt[m]));
		term = clip48(up + ui + udf);
		lo = (s.mode == ModeVelocity) ? 0 : OutLowPos;
		sat = term;
		if (sat > OutHigh) begin
			sat = OutHigh;
		end else if (sat < lo) begin
			sat = lo;
		end
		integ_acc[m] = ui;
		last_err[m] = err;
		deriv_filt[m] = udf;
		mag = (sat < 0) ? -sat : sat;
		r.drive = mag[25:16];
		if (s.mode == ModeVelocity) begin
			vel_excess = clip48(sat - term);
			r.direction = 1'b1;
		end else begin
			if (sat > 0) begin
				dir_hold = 1'b1;
			end else if (sat < 0) begin
				dir_hold = 1'b0;
			end
			r.direction = dir_hold;
		end
		return r;
	endfunction

	// Random gap length: mostly short, sometimes long.
	function automatic int pick_gap();
		if (calm) begin
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(20, 80);
		end
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	// Offers one sample and records the expected drive when the transaction completes.
	task automatic send_sample(pidaw_pkg::in_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (!in_ready);
		drive_expected.push_back(pid_step(s));
	endtask

	// Waits until every expected drive word has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		while (drive_expected.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Register write with a setup and an access phase; the shadow copy changes on the access edge.
	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= pidaw_pkg::AddrWidth'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			pidaw_pkg::RegPropGain: kp_q = longint'($signed(value));
			pidaw_pkg::RegIntegGain: ki_q = longint'($signed(value));
			pidaw_pkg::RegDerivGain: kd_q = longint'($signed(value));
			pidaw_pkg::RegWindupGain: kb_q = longint'($signed(value));
			pidaw_pkg::RegFilterAlpha: alpha_q = longint'(value[16:0]);
			default: ;
		endcase
	endtask

	task automatic set_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
		logic [31:0] kb, logic [31:0] alpha);
		reg_write(pidaw_pkg::RegPropGain, kp);
		reg_write(pidaw_pkg::RegIntegGain, ki);
		reg_write(pidaw_pkg::RegDerivGain, kd);
		reg_write(pidaw_pkg::RegWindupGain, kb);
		reg_write(pidaw_pkg::RegFilterAlpha, alpha);
	endtask

	function automatic pidaw_pkg::in_t make_sample(logic mode, logic [31:0] sp,
		logic [31:0] me);
		pidaw_pkg::in_t s;
		s.mode = mode;
		s.setpoint = sp;
		s.measured = me;
		return s;
	endfunction

	function automatic logic [31:0] rand_value();
		if ($urandom_range(0, 3) == 0) begin
			return $urandom;
		end
		return $urandom_range(0, 400_000_000) - 200_000_000;
	endfunction

	function automatic logic [31:0] rand_gain();
		if ($urandom_range(0, 7) == 0) begin
			return $urandom;
		end
		return $urandom_range(0, 8 * 65536) - 4 * 65536;
	endfunction

	// Zero gains after reset: zero drive, held direction low in position mode.
	task automatic test_reset_values();
		send_sample(make_sample(ModePosition, 32'h0001_0000, 32'h0));
		send_sample(make_sample(ModeVelocity, 32'h7FFF_FFFF, 32'h8000_0000));
		send_sample(make_sample(ModePosition, 32'h8000_0000, 32'h7FFF_FFFF));
		drain();
	endtask

	// Field extremes, both modes, zero position output and alpha limits.
	task automatic test_directed();
		set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'h0001_0000, 32'h1_0000);
		reg_write(RegUnused, 32'hFFFF_FFFF);
		send_sample(make_sample(ModePosition, 32'h7FFF_FFFF, 32'h8000_0000));
		send_sample(make_sample(ModePosition, 32'h8000_0000, 32'h7FFF_FFFF));
		send_sample(make_sample(ModePosition, 32'h0, 32'h0));
		send_sample(make_sample(ModePosition, 32'h0123_0000, 32'h0123_0000));
		send_sample(make_sample(ModeVelocity, 32'h7FFF_FFFF, 32'h8000_0000));
		send_sample(make_sample(ModeVelocity, 32'h8000_0000, 32'h7FFF_FFFF));
		send_sample(make_sample(ModeVelocity, 32'h0010_0000, 32'h0));
		send_sample(make_sample(ModeVelocity, 32'h0, 32'h0));
		drain();
		// Alpha of zero freezes the filter; above one it acts as one.
		reg_write(pidaw_pkg::RegFilterAlpha, 32'h0);
		send_sample(make_sample(ModePosition, 32'h0200_0000, 32'hFF00_0000));
		send_sample(make_sample(ModeVelocity, 32'h0005_0000, 32'h0));
		drain();
		reg_write(pidaw_pkg::RegFilterAlpha, 32'h0001_FFFF);
		send_sample(make_sample(ModePosition, 32'h0300_0000, 32'h0));
		send_sample(make_sample(ModeVelocity, 32'hFF00_0000, 32'h0));
		drain();
		set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1_0000);
		send_sample(make_sample(ModeVelocity, 32'h7FFF_FFFF, 32'h8000_0000));
		send_sample(make_sample(ModePosition, 32'h8000_0000, 32'h7FFF_FFFF));
		drain();
		set_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
		send_sample(make_sample(ModeVelocity, 32'h7FFF_FFFF, 32'h8000_0000));
		send_sample(make_sample(ModePosition, 32'h7FFF_FFFF, 32'h8000_0000));
		send_sample(make_sample(ModeVelocity, 32'h0, 32'h0));
		drain();
	endtask

	// Random samples under several random gain settings.
	task automatic test_random(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
					: $urandom_range(0, 65536));
			calm = (p % 4 == 3);
			for (int i = 0; i < per_phase; i++) begin
				send_sample(make_sample($urandom_range(0, 1), rand_value(), rand_value()));
			end
			drain();
		end
		calm = 1'b0;
	endtask

	// Receiver stalls for a long time while samples keep coming.
	task automatic test_backpressure();
		hold_off_cycles = 2000;
		for (int i = 0; i < 6; i++) begin
			send_sample(make_sample($urandom_range(0, 1), rand_value(), rand_value()));
		end
		drain();
	endtask

	// Receiver ready with random stalls and an optional long hold-off.
	initial begin
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				out_ready <= 1'b0;
				hold_off_cycles--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// Compares each completed output transaction with the oldest expectation.
	always @(posedge clk) begin
		pidaw_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (drive_expected.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_data);
				failed = 1'b1;
			end else begin
				want = drive_expected.pop_front();
				if (out_data.drive !== want.drive) begin
					$display("%0t: drive expected %0d actual %0d", $time, want.drive,
						out_data.drive);
					failed = 1'b1;
				end
				if (out_data.direction !== want.direction) begin
					$display("%0t: direction expected %0d actual %0d", $time,
						want.direction, out_data.direction);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		failed = 1'b0;
		calm = 1'b0;
		hold_off_cycles = 0;
		kp_q = 0; ki_q = 0; kd_q = 0; kb_q = 0;
		alpha_q = UnitQ16;
		integ_acc = '{0, 0};
		last_err = '{0, 0};
		deriv_filt = '{0, 0};
		vel_excess = 0;
		dir_hold = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_values();
		test_directed();
		test_backpressure();
		test_random(8, 180);
		repeat (400) @(posedge clk);
		if (!failed && drive_expected.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
